// ===== design/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types, constants and the arctangent table for the tilt and fall
// detector.
// ----------------------------------------------------------------------------
package tfd_pkg;

   // Default number of CORDIC micro-rotations per pass.
   localparam int CORDIC_STEPS_DEF = 16;

   // Arctangent table length and the index width that covers it.
   localparam int ATAN_LEN = 24;
   localparam int ITER_W   = 5;

   // CORDIC vector width, angle accumulator width and table entry width.
   localparam int VEC_W  = 34;
   localparam int ACC_W  = 26;
   localparam int ATAN_W = 22;

   // Input prescale and the gain compensation factor round(65536 / K).
   localparam int PRESCALE = 14;
   localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

   // Half-plane base angle of 180 degrees in 1/65536 degree.
   localparam logic signed [ACC_W-1:0] BASE_180 = 26'sd11796480;

   // Output angle limits in 1/128 degree.
   localparam logic signed [16:0] PITCH_LIM = 17'sd11520;
   localparam logic signed [16:0] ROLL_LIM  = 17'sd23040;

   // Configuration register indexes.
   localparam logic REG_TILT_THRESHOLD = 1'b0;
   localparam logic REG_HOLD_SAMPLES   = 1'b1;

   // Event codes reported with each result.
   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_FALL     = 2'd1,
      EV_UPRIGHT  = 2'd2
   } tilt_event_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROLL,
      ST_SCALE,
      ST_PITCH_LOAD,
      ST_PITCH,
      ST_ANGLE,
      ST_COMMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load_roll;
      logic              step;
      logic              scale;
      logic              load_pitch;
      logic              angle;
      logic              commit;
      logic [ITER_W-1:0] iter;
   } dp_cmd_type;

   // atan(2^-i) in degrees times 65536, rounded to nearest.
   function automatic logic [ATAN_W-1:0] atan_lookup(input logic [ITER_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234379;
         5'd5:    val = 22'd117304;
         5'd6:    val = 22'd58666;
         5'd7:    val = 22'd29335;
         5'd8:    val = 22'd14668;
         5'd9:    val = 22'd7334;
         5'd10:   val = 22'd3667;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd917;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd115;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd29;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         5'd20:   val = 22'd4;
         5'd21:   val = 22'd2;
         5'd22:   val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== design/tfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tfd_ctrl
// Sequencer for the two CORDIC passes, the scaling multiply, the angle
// formatting and the result handoff.
// ----------------------------------------------------------------------------
module tfd_ctrl import tfd_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

   ctrl_state_type    state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // State, iteration counter and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      cmd.iter = iter_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_roll = 1'b1;
               iter_in       = '0;
               state_in      = ST_ROLL;
            end
         end
         ST_ROLL: begin
            cmd.step = 1'b1;
            if (iter_ff == ITER_LAST) begin
               iter_in  = '0;
               state_in = ST_SCALE;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_PITCH_LOAD;
         end
         ST_PITCH_LOAD: begin
            cmd.load_pitch = 1'b1;
            iter_in        = '0;
            state_in       = ST_PITCH;
         end
         ST_PITCH: begin
            cmd.step = 1'b1;
            if (iter_ff == ITER_LAST) begin
               iter_in  = '0;
               state_in = ST_ANGLE;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_ANGLE: begin
            cmd.angle = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register fills on commit and empties when taken.
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/tfd_datapath.sv =====
// ----------------------------------------------------------------------------
// tfd_datapath
// Shared CORDIC vectoring unit, gain compensation multiply, angle formatting,
// tipped-sample counter and the result register.
// ----------------------------------------------------------------------------
module tfd_datapath import tfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic        [14:0] csr_wdata,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_roll_angle,
   output logic        [1:0]  rsp_tilt_event,
   output logic               rsp_is_fallen
);

   // Round to 1/128 degree (half up) and clamp to a symmetric limit.
   function automatic logic signed [16:0] to_q7(input logic signed [ACC_W-1:0] acc,
                                                input logic signed [16:0] lim);
      logic signed [ACC_W-1:0] sum;
      logic signed [16:0]      r;
      sum = acc + ACC_W'(256);
      r   = 17'(sum >>> 9);
      if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   logic        [14:0]       thr_ff;
   logic        [7:0]        hold_ff;
   logic        [7:0]        cnt_ff, cnt_in;
   logic                     fallen_ff, fallen_in;

   logic signed [VEC_W-1:0]  x_ff, y_ff;
   logic signed [ACC_W-1:0]  acc_ff, base_ff, roll_acc_ff;
   logic                     zero_ff;
   logic signed [15:0]       ax_ff;
   logic        [46:0]       prod_ff;
   logic signed [14:0]       pitch_ff;
   logic signed [15:0]       roll_ff;

   logic signed [14:0]       out_pitch_ff;
   logic signed [15:0]       out_roll_ff;
   tilt_event_type           out_event_ff, event_in;
   logic                     out_fallen_ff;

   logic signed [VEC_W-1:0]  ax_v, ay_v, az_v;
   logic signed [VEC_W-1:0]  dx, dy;
   logic signed [ACC_W-1:0]  atan_v;
   logic        [30:0]       mag;
   logic signed [16:0]       pitch_q, roll_q;
   logic        [14:0]       pitch_abs;
   logic        [15:0]       roll_abs;
   logic                     tipped;
   logic        [7:0]        cnt_inc;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= 15'd5760;
         hold_ff <= 8'd3;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_TILT_THRESHOLD: thr_ff  <= csr_wdata;
            REG_HOLD_SAMPLES:   hold_ff <= csr_wdata[7:0];
            default:            thr_ff  <= thr_ff;
         endcase
      end
   end

   // Prescaled axes and the current micro-rotation terms.
   assign ax_v   = {{4{req_accel_x[15]}}, req_accel_x, {PRESCALE{1'b0}}};
   assign ay_v   = {{4{req_accel_y[15]}}, req_accel_y, {PRESCALE{1'b0}}};
   assign az_v   = {{4{req_accel_z[15]}}, req_accel_z, {PRESCALE{1'b0}}};
   assign dx     = y_ff >>> cmd.iter;
   assign dy     = x_ff >>> cmd.iter;
   assign atan_v = ACC_W'(atan_lookup(cmd.iter));
   assign mag    = prod_ff[46:16];

   // CORDIC vector, angle accumulator and pass bookkeeping.
   always_ff @(posedge clock) begin
      if (cmd.load_roll) begin
         // Left half plane: rotate by 180 degrees before vectoring.
         if (req_accel_z < 0) begin
            x_ff    <= -az_v;
            y_ff    <= -ay_v;
            base_ff <= (req_accel_y >= 0) ? BASE_180 : -BASE_180;
         end else begin
            x_ff    <= az_v;
            y_ff    <= ay_v;
            base_ff <= '0;
         end
         acc_ff  <= '0;
         zero_ff <= (req_accel_z == 0) && (req_accel_y == 0);
         ax_ff   <= req_accel_x;
      end else if (cmd.load_pitch) begin
         x_ff    <= VEC_W'(mag);
         y_ff    <= -{{4{ax_ff[15]}}, ax_ff, {PRESCALE{1'b0}}};
         acc_ff  <= '0;
         zero_ff <= (mag == '0) && (ax_ff == 0);
      end else if (cmd.step) begin
         // Rotate toward the x axis; a zero vector keeps angle zero.
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            if (!zero_ff) begin
               acc_ff <= acc_ff + atan_v;
            end
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            if (!zero_ff) begin
               acc_ff <= acc_ff - atan_v;
            end
         end
      end
      if (cmd.scale) begin
         roll_acc_ff <= acc_ff + base_ff;
         prod_ff     <= x_ff[30:0] * INV_GAIN_Q16;
      end
      if (cmd.angle) begin
         pitch_ff <= pitch_q[14:0];
         roll_ff  <= roll_q[15:0];
      end
   end

   assign pitch_q = to_q7(acc_ff, PITCH_LIM);
   assign roll_q  = to_q7(roll_acc_ff, ROLL_LIM);

   // Tipped decision and the fall / upright counter.
   assign pitch_abs = pitch_ff[14] ? 15'(-pitch_ff) : 15'(pitch_ff);
   assign roll_abs  = roll_ff[15] ? 16'(-roll_ff) : 16'(roll_ff);
   assign tipped    = (pitch_abs > thr_ff) || (roll_abs > {1'b0, thr_ff});
   assign cnt_inc   = (cnt_ff < hold_ff) ? cnt_ff + 8'd1 : cnt_ff;

   always_comb begin
      cnt_in    = cnt_ff;
      fallen_in = fallen_ff;
      event_in  = EV_NONE;
      if (tipped) begin
         cnt_in = cnt_inc;
         if ((cnt_inc >= hold_ff) && !fallen_ff) begin
            fallen_in = 1'b1;
            event_in  = EV_FALL;
         end
      end else begin
         cnt_in = '0;
         if (fallen_ff) begin
            fallen_in = 1'b0;
            event_in  = EV_UPRIGHT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         fallen_ff <= 1'b0;
      end else if (cmd.commit) begin
         cnt_ff    <= cnt_in;
         fallen_ff <= fallen_in;
      end
   end

   // Result register, loaded when the transaction is committed.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_pitch_ff  <= pitch_ff;
         out_roll_ff   <= roll_ff;
         out_event_ff  <= event_in;
         out_fallen_ff <= fallen_in;
      end
   end

   assign rsp_pitch_angle = out_pitch_ff;
   assign rsp_roll_angle  = out_roll_ff;
   assign rsp_tilt_event  = out_event_ff;
   assign rsp_is_fallen   = out_fallen_ff;

endmodule

// ===== design/tilt_fall_detector.sv =====
// ----------------------------------------------------------------------------
// tilt_fall_detector
// Accelerometer tilt estimation with fall and upright event reporting.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result: roll = atan2(y, z) and
// pitch = atan2(-x, sqrt(y^2 + z^2)) in 1/128 degree, plus a fall or upright
// event and the current fallen flag. From acceptance to the result register
// a sample runs through the single shared CORDIC unit: the roll pass, the
// gain compensation multiply, the loading of the pitch vector and the pitch
// pass, each pass one micro-rotation per cycle, then angle formatting and
// the commit. The input stalls during that time; the next sample is taken
// on the cycle after the commit, so a new sample is accepted only once the
// previous one has been committed, while the previous result may still wait
// in the output register. A commit waits only when the output register is
// still full and stalled. Configuration writes take effect at once and
// should be made while no sample is in flight.
module tilt_fall_detector import tfd_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_roll_angle,
   output logic        [1:0]  rsp_tilt_event,
   output logic               rsp_is_fallen,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic        [14:0] csr_wdata
);

   dp_cmd_type cmd;

   // Sequencer.
   tfd_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Arithmetic, state and result register.
   tfd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_tilt_event  (rsp_tilt_event),
      .rsp_is_fallen   (rsp_is_fallen)
   );

endmodule

// ===== design/tfd_checker.sv =====
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level checks for the tilt and fall detector, bound to the top level.
// ----------------------------------------------------------------------------
module tfd_checker import tfd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [14:0] rsp_pitch_angle,
   input logic signed [15:0] rsp_roll_angle,
   input logic        [1:0]  rsp_tilt_event,
   input logic               rsp_is_fallen
);

   // A stalled result holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pitch_angle)
         && $stable(rsp_roll_angle) && $stable(rsp_tilt_event)
         && $stable(rsp_is_fallen))
      else $error("stalled result changed");

   // After a transaction is accepted the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after acceptance");

   // Events agree with the reported fallen flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tilt_event == EV_FALL) |-> rsp_is_fallen)
      else $error("fall event without fallen flag");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tilt_event == EV_UPRIGHT) |-> !rsp_is_fallen)
      else $error("upright event with fallen flag");

   // Angles stay within their documented ranges.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= 16'sd23040) && (rsp_roll_angle >= -16'sd23040)
         && (rsp_pitch_angle <= 15'sd11520) && (rsp_pitch_angle >= -15'sd11520))
      else $error("angle out of range");

endmodule

bind tilt_fall_detector tfd_checker u_checker (.*);

// ===== bench/tilt_fall_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tilt_fall_checker
// Watches the sample, result and register ports of the tilt and fall
// detector, predicts every result and compares it with what the block sends.
// ----------------------------------------------------------------------------
// The predictor keeps its own copy of the threshold, the hold count, the
// tipped-sample counter and the fallen flag. Each accepted sample runs two
// CORDIC vectoring passes in 64-bit integers, and the expected result is
// queued until the block hands over a result transaction.
module tilt_fall_checker import tfd_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [14:0] rsp_pitch_angle,
   input  logic signed [15:0] rsp_roll_angle,
   input  logic        [1:0]  rsp_tilt_event,
   input  logic               rsp_is_fallen,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic        [14:0] csr_wdata,
   output int                 pending_results,
   output int                 mismatch_count
);

   localparam longint PITCH_MAX       = 11520;
   localparam longint ROLL_MAX        = 23040;
   localparam longint HALF_TURN       = 180 * 65536;
   localparam longint GAIN_COMP_Q16   = 39797;
   localparam longint THRESHOLD_RESET = 5760;
   localparam int     HOLD_RESET      = 3;
   localparam int     ARCTAN_LEN      = 24;

   // Arctangent of 2^-i in 1/65536 degree.
   localparam longint ARCTAN_DEG [ARCTAN_LEN] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic signed [14:0] pitch;
      logic signed [15:0] roll;
      tilt_event_type     tilt_event;
      logic               fallen;
   } tilt_result_type;

   longint          threshold_reg;
   int              hold_reg;
   int              tipped_run;
   bit              fallen_now;
   tilt_result_type expected_q [$];

   // Vectoring pass with a non-negative x: rotates y to zero and returns the
   // angle turned through; the final x is the uncompensated magnitude.
   function automatic longint vector_angle(input longint vx, input longint vy,
                                           output longint vmag);
      longint acc;
      longint dx;
      longint dy;
      int     i;
      acc = 0;
      vmag = 0;
      if (vx == 0 && vy == 0) begin
         return 0;
      end
      for (i = 0; i < STEPS && i < ARCTAN_LEN; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy > 0) begin
            vx = vx + dx;
            vy = vy - dy;
            acc = acc + ARCTAN_DEG[i];
         end else begin
            vx = vx - dx;
            vy = vy + dy;
            acc = acc - ARCTAN_DEG[i];
         end
      end
      vmag = vx;
      return acc;
   endfunction

   // Round half up from 1/65536 to 1/128 degree, then clamp.
   function automatic longint to_angle_q7(input longint acc, input longint lim);
      longint r;
      r = (acc + 256) >>> 9;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   // Computes the result of one sample and advances the fall tracking state.
   function automatic tilt_result_type predict_tilt(input logic signed [15:0] ax_in,
                                                    input logic signed [15:0] ay_in,
                                                    input logic signed [15:0] az_in);
      longint          ax;
      longint          ay;
      longint          az;
      longint          roll_acc;
      longint          pitch_acc;
      longint          mraw;
      longint          mag;
      longint          pitch;
      longint          roll;
      bit              tipped;
      tilt_result_type res;
      ax = longint'(ax_in) * 16384;
      ay = longint'(ay_in) * 16384;
      az = longint'(az_in) * 16384;

      // Roll pass; a vector in the left half plane is turned by half a circle.
      if (az < 0) begin
         roll_acc = vector_angle(-az, -ay, mraw) + ((ay >= 0) ? HALF_TURN : -HALF_TURN);
      end else begin
         roll_acc = vector_angle(az, ay, mraw);
      end

      // Pitch pass on the gain-compensated magnitude of the y-z vector.
      mag = (mraw * GAIN_COMP_Q16) >>> 16;
      pitch_acc = vector_angle(mag, -ax, mraw);

      pitch = to_angle_q7(pitch_acc, PITCH_MAX);
      roll = to_angle_q7(roll_acc, ROLL_MAX);
      tipped = ((pitch < 0 ? -pitch : pitch) > threshold_reg) ||
               ((roll < 0 ? -roll : roll) > threshold_reg);

      res.tilt_event = EV_NONE;
      if (tipped) begin
         if (tipped_run < hold_reg) tipped_run++;
         if (tipped_run >= hold_reg && !fallen_now) begin
            fallen_now = 1'b1;
            res.tilt_event = EV_FALL;
         end
      end else begin
         tipped_run = 0;
         if (fallen_now) begin
            fallen_now = 1'b0;
            res.tilt_event = EV_UPRIGHT;
         end
      end
      res.pitch = pitch[14:0];
      res.roll = roll[15:0];
      res.fallen = fallen_now;
      return res;
   endfunction

   task automatic report_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Results are checked before new samples are predicted; register writes
   // only happen while the block is idle.
   always @(posedge clock) begin
      tilt_result_type want;
      if (reset) begin
         threshold_reg = THRESHOLD_RESET;
         hold_reg = HOLD_RESET;
         tipped_run = 0;
         fallen_now = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: result transaction with no sample outstanding", $time);
            end else begin
               want = expected_q.pop_front();
               report_field("pitch_angle", want.pitch, rsp_pitch_angle);
               report_field("roll_angle", want.roll, rsp_roll_angle);
               report_field("tilt_event", want.tilt_event, rsp_tilt_event);
               report_field("is_fallen", want.fallen, rsp_is_fallen);
            end
         end
         if (req_valid && !req_stall) begin
            expected_q.push_back(predict_tilt(req_accel_x, req_accel_y, req_accel_z));
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_TILT_THRESHOLD: threshold_reg = longint'(csr_wdata);
               REG_HOLD_SAMPLES:   hold_reg = int'(csr_wdata[7:0]);
               default: ;
            endcase
         end
      end
      pending_results = expected_q.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the tilt and fall detector.
// ----------------------------------------------------------------------------
// A short directed set of corner samples runs first under the reset
// configuration, then phases of random tipped and upright stretches under
// several thresholds and hold counts, the extremes among them. Both the
// sample sender and the result receiver idle at random, the receiver once
// holds off long enough to back the block up, and the checker beside the
// block predicts and compares every result.
module testbench;
   import tfd_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int IDLE_LIMIT    = 2000;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 50;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } accel_type;

   typedef enum int {
      SAMPLE_UPRIGHT,
      SAMPLE_TIPPED,
      SAMPLE_NOISE
   } sample_kind_type;

   // Zero vectors, single axes, both half planes and full-scale corners.
   localparam accel_type CORNER_LIST [21] = '{
      '{16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd1},
      '{16'sd1, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd1, 16'sd0},
      '{-16'sd1, -16'sd1, -16'sd1},
      '{16'sd0, 16'sd0, 16'sd16384},
      '{16'sd0, 16'sd16384, 16'sd0},
      '{16'sd0, -16'sd16384, 16'sd0},
      '{16'sd0, 16'sd0, -16'sd16384},
      '{16'sd0, -16'sd1, -16'sd16384},
      '{16'sd0, 16'sd0, 16'sd16384},
      '{16'sd32767, 16'sd0, 16'sd0},
      '{16'sh8000, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sh8000},
      '{16'sd0, 16'sh8000, 16'sh8000},
      '{16'sd32767, 16'sd32767, 16'sd32767},
      '{16'sh8000, 16'sh8000, 16'sh8000},
      '{16'sh8000, 16'sd32767, 16'sh8000},
      '{16'sd32767, 16'sh8000, 16'sd32767},
      '{16'sd0, 16'sd0, 16'sd32767},
      '{16'sd0, 16'sd0, 16'sd16384}
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_accel_x;
   logic signed [15:0] req_accel_y;
   logic signed [15:0] req_accel_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [14:0] rsp_pitch_angle;
   logic signed [15:0] rsp_roll_angle;
   logic        [1:0]  rsp_tilt_event;
   logic               rsp_is_fallen;
   logic               csr_wr_en;
   logic               csr_index;
   logic        [14:0] csr_wdata;
   int                 pending_results;
   int                 mismatch_count;

   // Idle percentages per phase and the request for a long receiver hold-off.
   int stall_pct = 0;
   int send_idle_pct = 0;
   bit hold_off_toggle = 1'b0;

   tilt_fall_detector dut (.*);

   tilt_fall_checker checker_inst (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Mostly short gaps, some medium, a few long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   function automatic logic signed [15:0] corner_value();
      case ($urandom_range(4))
         0:       return 16'sh8000;
         1:       return -16'sd1;
         2:       return 16'sd0;
         3:       return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   function automatic logic signed [15:0] near_zero(input int span);
      return 16'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic accel_type make_sample(input sample_kind_type kind);
      accel_type s;
      int        lim;
      s.x = 16'($urandom);
      s.y = 16'($urandom);
      s.z = 16'($urandom);
      case (kind)
         SAMPLE_UPRIGHT: begin
            // Gravity mostly along +z with a modest lean.
            s.z = 16'($urandom_range(4000, 32767));
            lim = int'(s.z) / 6;
            s.x = near_zero(lim);
            s.y = near_zero(lim);
         end
         SAMPLE_TIPPED: begin
            // Either upside down or lying on the x axis.
            if ($urandom_range(1) == 1) begin
               s.z = 16'(-int'($urandom_range(1, 32768)));
            end else begin
               s.x = ($urandom_range(1) == 1) ? 16'($urandom_range(8000, 32767))
                                              : 16'(-int'($urandom_range(8000, 32768)));
               s.y = near_zero(2000);
               s.z = near_zero(2000);
            end
         end
         default: begin
            case ($urandom_range(3))
               2: begin
                  s.x = near_zero(8);
                  s.y = near_zero(8);
                  s.z = near_zero(8);
               end
               3: begin
                  s.x = corner_value();
                  s.y = corner_value();
                  s.z = corner_value();
               end
               default: ;
            endcase
         end
      endcase
      return s;
   endfunction

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Offers one sample and holds it until the block accepts the transaction.
   task automatic send_sample(input accel_type s);
      @(negedge clock);
      req_valid <= 1'b1;
      req_accel_x <= s.x;
      req_accel_y <= s.y;
      req_accel_z <= s.z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) pause_sender(gap_len());
   endtask

   // Stops sending and waits until every outstanding result has been taken.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results == 0);
   endtask

   task automatic write_register(input logic index, input logic [14:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Tipped stretches around the hold count, upright stretches and some noise.
   task automatic run_episodes(input int item_count, input int hold);
      int sent;
      int run;
      int k;
      sent = 0;
      while (sent < item_count) begin
         run = $urandom_range(0, hold + 2);
         for (k = 0; k < run && sent < item_count; k++) begin
            send_sample(make_sample(SAMPLE_TIPPED));
            sent++;
         end
         run = $urandom_range(1, 4);
         for (k = 0; k < run && sent < item_count; k++) begin
            send_sample(make_sample(SAMPLE_UPRIGHT));
            sent++;
         end
         if ($urandom_range(99) < 25 && sent < item_count) begin
            send_sample(make_sample(SAMPLE_NOISE));
            sent++;
         end
      end
   endtask

   task automatic run_phase(input logic [14:0] threshold, input logic [14:0] hold_word,
                            input int item_count, input int stall, input int idle);
      drain_results();
      write_register(REG_TILT_THRESHOLD, threshold);
      write_register(REG_HOLD_SAMPLES, hold_word);
      stall_pct = stall;
      send_idle_pct = idle;
      run_episodes(item_count, int'(hold_word[7:0]));
   endtask

   // Result receiver: random stall runs, plus one long hold-off on request.
   initial begin : receiver
      bit seen_toggle;
      seen_toggle = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_toggle != seen_toggle) begin
            seen_toggle = hold_off_toggle;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if ($urandom_range(99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat (gap_len() - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Ends the run when no transaction has moved for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tilt_fall_detector test failed");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      csr_wr_en = 1'b0;
      csr_index = REG_TILT_THRESHOLD;
      csr_wdata = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corner samples under the reset configuration, including a fall with
      // counter saturation and the recovery after it.
      foreach (CORNER_LIST[i]) send_sample(CORNER_LIST[i]);

      stall_pct = 30;
      send_idle_pct = 30;
      run_episodes(100, 3);

      // Long receiver hold-off while samples keep coming, then a full drain.
      hold_off_toggle = ~hold_off_toggle;
      send_idle_pct = 0;
      run_episodes(8, 3);
      drain_results();
      send_idle_pct = 30;
      run_episodes(92, 3);

      run_phase(15'd0, 15'd0, 150, 0, 0);
      run_phase(15'd11520, 15'd255, 450, 30, 20);
      run_phase(15'd23040, 15'd0, 150, 50, 40);
      // Upper bits of the hold word fall outside the register.
      run_phase(15'h7FFF, 15'h7F02, 150, 20, 10);
      run_phase(15'd1, 15'd1, 150, 10, 60);
      repeat (3) begin
         run_phase(15'($urandom_range(0, 23040)), 15'($urandom_range(0, 6)), 150,
                   $urandom_range(0, 60), $urandom_range(0, 60));
      end
      run_phase(15'd5760, 15'd3, 150, 30, 30);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tilt_fall_detector test passed");
      end else begin
         $display("tilt_fall_detector test failed");
      end
      $finish;
   end

endmodule
